// ----- rtl/core/ahmr_pkg.sv -----
// ----------------------------------------------------------------------------
// ahmr_pkg
// Shared types and codes for the age histogram with rank and mean queries.
// ----------------------------------------------------------------------------
package ahmr_pkg;

  // field widths of the request and result channels
  localparam int CMD_W    = 2;
  localparam int AGE_W    = 7;
  localparam int RANK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int MEAN_W   = 15;
  localparam int TOTAL_W  = 16;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MEAN_W-1:0]   mean_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  // command codes
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_RANK  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  // status codes
  localparam status_t STS_OK    = 2'd0;
  localparam status_t STS_RANGE = 2'd1;
  localparam status_t STS_RANK  = 2'd2;
  localparam status_t STS_FULL  = 2'd3;

  // saturation limits
  localparam total_t TOTAL_MAX = '1;
  localparam mean_t  MEAN_MAX  = '1;

endpackage

// ----- rtl/core/ahmr_if.sv -----
// ----------------------------------------------------------------------------
// ahmr request and result channels
// Valid/ready channels carrying one command request and one result each.
// ----------------------------------------------------------------------------
interface ahmr_req_if import ahmr_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  age_t  age_value;
  rank_t rank_index;

  modport source (output valid, output cmd, output age_value, output rank_index,
                  input ready);
  modport sink (input valid, input cmd, input age_value, input rank_index,
                output ready);
endinterface

interface ahmr_rsp_if import ahmr_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  age_t    rank_value;
  mean_t   mean_q8;
  total_t  total_count;

  modport source (output valid, output status, output rank_value, output mean_q8,
                  output total_count, input ready);
  modport sink (input valid, input status, input rank_value, input mean_q8,
                input total_count, output ready);
endinterface

// ----- rtl/core/ahmr_ram.sv -----
// ----------------------------------------------------------------------------
// ahmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 101
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ahmr_div.sv -----
// ----------------------------------------------------------------------------
// ahmr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ahmr_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] steps;
  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // one trial subtraction per step
  always_comb begin
    shifted  = {rem, work[NUM_W-1]};
    diff     = shifted - {1'b0, den};
    qbit     = ~diff[DEN_W];
    rem_next = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      steps <= CNT_W'(NUM_W);
    end else if (busy) begin
      work  <= {work[NUM_W-2:0], qbit};
      rem   <= rem_next;
      steps <= steps - CNT_W'(1);
    end
  end

  assign quot = work;

  // a new division never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // done pulses only at the end of a run
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");

  // the remainder stays below the divisor while running
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy && !start |-> rem < den)
    else $error("divider remainder out of bound");

endmodule

// ----- rtl/core/age_histogram_mean_rank.sv -----
// ----------------------------------------------------------------------------
// age_histogram_mean_rank
// Age histogram with add, clear and rank query; reports total and Q8 mean.
// ----------------------------------------------------------------------------
// One request is handled at a time and the request side is not ready until
// the result is built. Counts per age live in a RAM with a registered read
// port and a valid bit per entry, so reset and clear take effect at once.
// An accepted add reads its bin, writes the incremented count and then runs
// the bit-serial divider that refreshes the mean. A rank query walks the
// bins one RAM read per cycle until the running sum passes the rank. Clear,
// an out-of-range age, a full total, an out-of-range rank and the unused
// code go straight to the output state; an add to a full bin stops after
// its read and reports full. A finished result waits in an output register
// while the next request is accepted.
// ----------------------------------------------------------------------------
module age_histogram_mean_rank import ahmr_pkg::*; #(
  parameter int MAX_AGE     = 100,
  parameter int COUNT_WIDTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  ahmr_req_if.sink   req,
  ahmr_rsp_if.source rsp
);

  localparam int BINS  = MAX_AGE + 1;
  localparam int BW    = $clog2(BINS);
  localparam int SUM_W = TOTAL_W + BW;
  localparam int NUM_W = SUM_W + 8;
  localparam int ACC_W = TOTAL_W + 1;

  localparam logic [BW-1:0] LAST_BIN = BW'(MAX_AGE);
  localparam logic [7:0]    AGE_LIM  = 8'(MAX_AGE);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RD = 3'd1;
  localparam logic [2:0] S_ADD_WR = 3'd2;
  localparam logic [2:0] S_DIV_GO = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]             state;
  logic [BW-1:0]          age_idx;
  rank_t                  rank_r;
  status_t                status_r;
  logic [BW-1:0]          value_r;
  total_t                 total;
  logic [SUM_W-1:0]       sum;
  mean_t                  mean;
  logic [BINS-1:0]        valid_bits;
  logic [BW-1:0]          walk_idx;
  logic [BW-1:0]          pend_idx;
  logic                   pend;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       acc_next;

  logic                   accept;
  logic                   age_bad;
  logic                   ram_we;
  logic [BW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [BW-1:0]          cnt_idx;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign age_bad   = {1'b0, req.age_value} > AGE_LIM;

  // count read back, zero for bins not written since the last clear
  always_comb begin
    cnt_idx   = (state == S_WALK) ? pend_idx : age_idx;
    cnt       = valid_bits[cnt_idx] ? ram_rdata : '0;
    ram_raddr = (state == S_WALK) ? walk_idx : age_idx;
    ram_we    = (state == S_ADD_WR) && !(&cnt);
    acc_next  = acc + ACC_W'(cnt);
  end

  ahmr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (age_idx),
    .wdata (cnt + COUNT_WIDTH'(1)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ahmr_div #(
    .NUM_W (NUM_W),
    .DEN_W (TOTAL_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   ({sum, 8'd0}),
    .den   (total),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer and store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      sum        <= '0;
      mean       <= '0;
      valid_bits <= '0;
      pend       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.cmd)
              CMD_ADD: begin
                if (age_bad) begin
                  status_r <= STS_RANGE;
                  state    <= S_OUT;
                end else if (total == TOTAL_MAX) begin
                  status_r <= STS_FULL;
                  state    <= S_OUT;
                end else begin
                  state <= S_ADD_RD;
                end
              end
              CMD_RANK: begin
                if (ACC_W'(req.rank_index) >= ACC_W'(total)) begin
                  status_r <= STS_RANK;
                  state    <= S_OUT;
                end else begin
                  state <= S_WALK;
                end
              end
              CMD_CLEAR: begin
                valid_bits <= '0;
                total      <= '0;
                sum        <= '0;
                mean       <= '0;
                status_r   <= STS_OK;
                state      <= S_OUT;
              end
              default: begin
                status_r <= STS_OK;
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_ADD_RD: begin
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          if (&cnt) begin
            status_r <= STS_FULL;
            state    <= S_OUT;
          end else begin
            valid_bits[age_idx] <= 1'b1;
            total               <= total + TOTAL_W'(1);
            sum                 <= sum + SUM_W'(age_idx);
            status_r            <= STS_OK;
            state               <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= (div_quot > NUM_W'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(div_quot);
            state <= S_OUT;
          end
        end
        S_WALK: begin
          if (pend && acc_next > ACC_W'(rank_r)) begin
            status_r <= STS_OK;
            pend     <= 1'b0;
            state    <= S_OUT;
          end else begin
            pend <= 1'b1;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and rank walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      age_idx  <= BW'(req.age_value);
      rank_r   <= req.rank_index;
      value_r  <= '0;
      walk_idx <= '0;
      acc      <= '0;
    end else if (state == S_WALK) begin
      pend_idx <= walk_idx;
      if (walk_idx != LAST_BIN) begin
        walk_idx <= walk_idx + BW'(1);
      end
      if (pend) begin
        acc     <= acc_next;
        value_r <= pend_idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= status_r;
      rsp.rank_value  <= (status_r == STS_OK) ? AGE_W'(value_r) : '0;
      rsp.mean_q8     <= mean;
      rsp.total_count <= total;
    end
  end

  // total moves only by one step up or back to zero
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && total != $past(total) |-> total == $past(total) + TOTAL_W'(1) ||
    total == '0)
    else $error("total changed by an illegal step");

  // the walk never addresses past the last bin
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_idx <= LAST_BIN)
    else $error("rank walk past last bin");

  // a new result is only presented after the output state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(rsp.valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

  // empty store has a zero mean
  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    total == '0 |-> mean == '0)
    else $error("nonzero mean on empty store");

endmodule

// ----- tb/sv/tb_age_histogram_mean_rank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_age_histogram_mean_rank
// Self-checking bench for the age histogram: a clocked driver feeds add,
// rank, clear and unused-code requests from a queue, a clocked monitor
// compares every result field against a cycle-free histogram predictor.
// The block is built with its default bin count and count width.
// ----------------------------------------------------------------------------
module tb_age_histogram_mean_rank;
  import ahmr_pkg::*;

  localparam int BIN_TOP     = 100;
  localparam int BIN_CNT_W   = 16;
  localparam int BIN_FULL    = (1 << BIN_CNT_W) - 1;
  localparam int BIN_RUN     = 60;
  localparam int SUM_W       = 23;
  localparam int RANDOM_REQS = 1100;
  localparam int IDLE_PCT    = 29;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;

  typedef struct {
    cmd_t  cmd;
    age_t  age;
    rank_t rank;
    bit    drain_first;
  } hist_req_t;

  typedef struct {
    status_t status;
    age_t    rank_value;
    mean_t   mean_q8;
    total_t  total_count;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ahmr_req_if req_ch ();
  ahmr_rsp_if rsp_ch ();

  age_histogram_mean_rank #(
    .MAX_AGE     (BIN_TOP),
    .COUNT_WIDTH (BIN_CNT_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predicted histogram state
  logic [BIN_CNT_W-1:0] bin_count [0:BIN_TOP];
  total_t               occ_total;
  logic [SUM_W-1:0]     age_sum;

  hist_req_t    pending_reqs[$];
  hist_result_t awaited_results[$];

  // generator-side shadow, used only to aim rank queries
  int gen_bins [0:BIN_TOP];
  int gen_total = 0;

  int   accepted_reqs = 0;
  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  bit   req_taken     = 1'b0;
  logic calm_window;

  // no idling on either side for a stretch of requests
  assign calm_window = (accepted_reqs >= 600) && (accepted_reqs < 900);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void hist_clear();
    foreach (bin_count[i]) bin_count[i] = '0;
    occ_total = '0;
    age_sum   = '0;
  endfunction

  function automatic mean_t hist_mean();
    longint unsigned q;
    if (occ_total == '0) return '0;
    q = (longint'(age_sum) * 256) / longint'(occ_total);
    if (q > MEAN_MAX) q = MEAN_MAX;
    return mean_t'(q);
  endfunction

  // apply one request to the predicted state and build its result
  function automatic hist_result_t hist_apply(hist_req_t r);
    hist_result_t res;
    int unsigned  cum;
    res.status     = STS_OK;
    res.rank_value = '0;
    case (r.cmd)
      CMD_ADD: begin
        if (r.age > BIN_TOP) begin
          res.status = STS_RANGE;
        end else if (bin_count[r.age] == {BIN_CNT_W{1'b1}} || occ_total == TOTAL_MAX) begin
          res.status = STS_FULL;
        end else begin
          bin_count[r.age] = bin_count[r.age] + 1'b1;
          occ_total        = occ_total + 1'b1;
          age_sum          = age_sum + r.age;
        end
      end
      CMD_RANK: begin
        if (r.rank >= occ_total) begin
          res.status = STS_RANK;
        end else begin
          cum = 0;
          for (int a = 0; a <= BIN_TOP; a++) begin
            cum += bin_count[a];
            if (cum > r.rank) begin
              res.rank_value = age_t'(a);
              break;
            end
          end
        end
      end
      CMD_CLEAR: hist_clear();
      default: ;
    endcase
    res.mean_q8     = hist_mean();
    res.total_count = occ_total;
    return res;
  endfunction

  task automatic push_req(cmd_t c, int age, int rank, bit drain);
    hist_req_t r;
    r.cmd         = c;
    r.age         = age_t'(age);
    r.rank        = rank_t'(rank);
    r.drain_first = drain;
    pending_reqs.push_back(r);
    if (c == CMD_ADD && age <= BIN_TOP) begin
      if (gen_bins[age] < BIN_FULL && gen_total < 65535) begin
        gen_bins[age]++;
        gen_total++;
      end
    end else if (c == CMD_CLEAR) begin
      foreach (gen_bins[i]) gen_bins[i] = 0;
      gen_total = 0;
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // request driver, changes at the falling edge
  always @(negedge clk) begin : drive_req
    hist_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() > 0 && (calm_window || $urandom_range(0, 99) >= IDLE_PCT) &&
          (!pending_reqs[0].drain_first || awaited_results.size() == 0)) begin
        nxt = pending_reqs.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= nxt.cmd;
        req_ch.age_value  <= nxt.age;
        req_ch.rank_index <= nxt.rank;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && (calm_window || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // sample both channels at the rising edge, results before requests
  always @(posedge clk) begin : score
    hist_result_t want;
    hist_req_t    took;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with no request outstanding, status %0d total %0d",
                   $time, rsp_ch.status, rsp_ch.total_count);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("rank_value", want.rank_value, rsp_ch.rank_value);
          check_field("mean_q8", want.mean_q8, rsp_ch.mean_q8);
          check_field("total_count", want.total_count, rsp_ch.total_count);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        took.cmd         = req_ch.cmd;
        took.age         = req_ch.age_value;
        took.rank        = req_ch.rank_index;
        took.drain_first = 1'b0;
        awaited_results.push_back(hist_apply(took));
        req_taken = 1'b1;
        accepted_reqs++;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("age_histogram_mean_rank: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int   pick;
    int   sel;
    int   a;
    int   rk;
    cmd_t c;

    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_NOP;
    req_ch.age_value  = '0;
    req_ch.rank_index = '0;
    rsp_ch.ready      = 1'b0;
    foreach (gen_bins[i]) gen_bins[i] = 0;
    hist_clear();

    // empty store, unused code, clear of an empty store
    push_req(CMD_RANK, 0, 0, 1'b0);
    push_req(CMD_NOP, 127, 65535, 1'b0);
    push_req(CMD_CLEAR, 0, 0, 1'b0);
    // extremes of age, out of range ages
    push_req(CMD_ADD, 0, 0, 1'b0);
    push_req(CMD_ADD, 100, 0, 1'b0);
    push_req(CMD_ADD, 101, 0, 1'b0);
    push_req(CMD_ADD, 127, 0, 1'b0);
    push_req(CMD_ADD, 50, 65535, 1'b0);
    // rank walk over the sorted series and past its end
    push_req(CMD_RANK, 127, 0, 1'b0);
    push_req(CMD_RANK, 0, 1, 1'b0);
    push_req(CMD_RANK, 0, 2, 1'b0);
    push_req(CMD_RANK, 0, 3, 1'b0);
    push_req(CMD_RANK, 0, 65535, 1'b0);
    push_req(CMD_ADD, 100, 0, 1'b0);
    push_req(CMD_RANK, 0, 3, 1'b0);
    push_req(CMD_NOP, 0, 0, 1'b0);
    push_req(CMD_CLEAR, 127, 65535, 1'b0);
    push_req(CMD_RANK, 0, 0, 1'b0);
    // highest possible mean
    push_req(CMD_ADD, 100, 0, 1'b0);
    push_req(CMD_RANK, 0, 0, 1'b0);

    // a long run on one bin, then rank queries around its edges
    push_req(CMD_CLEAR, 0, 0, 1'b1);
    for (int i = 0; i < BIN_RUN; i++)
      push_req(CMD_ADD, 7, $urandom_range(0, 65535), 1'b0);
    push_req(CMD_ADD, 7, 0, 1'b0);
    push_req(CMD_ADD, 8, 0, 1'b0);
    push_req(CMD_RANK, 0, BIN_RUN - 1, 1'b0);
    push_req(CMD_RANK, 0, BIN_RUN, 1'b0);
    push_req(CMD_RANK, 0, BIN_RUN + 1, 1'b0);
    push_req(CMD_ADD, 7, 0, 1'b0);

    // random mix, mostly valid adds and aimed rank queries
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      a    = $urandom_range(0, 127);
      rk   = $urandom_range(0, 65535);
      if (pick < 45) begin
        c = CMD_ADD;
        if (sel < 85)
          a = $urandom_range(0, BIN_TOP);
        else if (sel < 90)
          a = $urandom_range(0, 1) ? BIN_TOP : 0;
        else
          a = $urandom_range(BIN_TOP + 1, 127);
      end else if (pick < 90) begin
        c = CMD_RANK;
        if (sel < 60 && gen_total > 0)
          rk = $urandom_range(0, gen_total - 1);
        else if (sel < 85)
          rk = (gen_total + 3 > 65535) ? 65535 : gen_total + $urandom_range(0, 3);
      end else if (pick < 91) begin
        c = CMD_CLEAR;
      end else if (pick < 96) begin
        c = CMD_NOP;
      end else begin
        c = CMD_ADD;
      end
      push_req(c, a, rk, (i == 0) || ($urandom_range(0, 99) == 0));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("age_histogram_mean_rank: match");
    else
      $display("age_histogram_mean_rank: mismatch");
    $finish;
  end

endmodule
